>>> sv/lpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared widths, register indexes and the window record that travels from
// the sample front end to the correlation back end.
// ----------------------------------------------------------------------------
package lpc_pkg;

  localparam int SW  = 16;   // sample width
  localparam int NW  = 7;    // register and window length width
  localparam int SXW = 24;   // sum of samples
  localparam int SQW = 38;   // sum of squares
  localparam int SPW = 39;   // sum of cross products
  localparam int VW  = 50;   // variance and covariance terms
  localparam int OW  = 48;   // multiplier operands
  localparam int MW  = 96;   // product of two operands
  localparam int BW  = 124;  // root search words
  localparam int QW  = 15;   // quotient bits searched
  localparam int CW  = 16;   // correlation width

  localparam logic [QW-1:0] ONE_Q14 = 15'd16384;

  localparam logic [1:0] REG_LAG = 2'd0;
  localparam logic [1:0] REG_WIN = 2'd1;

  typedef struct packed {
    logic [NW-1:0]         n;
    logic signed [SXW-1:0] sx;
    logic signed [SXW-1:0] sy;
    logic signed [SQW-1:0] sxx;
    logic signed [SQW-1:0] syy;
    logic signed [SPW-1:0] sxy;
  } win_t;

endpackage
`default_nettype wire

>>> sv/lpc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpc_front
// Takes samples, pairs each with the one lag places earlier through a delay
// memory and accumulates the window sums; a finished window goes out as one
// record.
// ----------------------------------------------------------------------------
module lpc_front #(
  parameter int MAX_LAG    = 128,
  parameter int MAX_WINDOW = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic signed [15:0]        sample,
  input  wire logic [6:0]                lag,
  input  wire logic [6:0]                window_len,
  input  wire logic [1:0]                fifo_cnt,
  output logic                           win_push,
  output lpc_pkg::win_t                  win
);
  import lpc_pkg::*;

  localparam int AW = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;

  logic signed [SW-1:0] mem [MAX_LAG];
  logic [MAX_LAG-1:0]   vld;
  logic [7:0]           cnt;
  logic [AW-1:0]        wptr;
  logic [AW-1:0]        rd_addr;
  logic signed [SW-1:0] rd_data;
  logic                 rd_vld;

  logic                 s2_valid;
  logic signed [SW-1:0] s2_s;
  logic                 s2_acc;
  logic                 s2_byp;
  logic                 s2_last;
  logic [NW-1:0]        s2_n;

  logic signed [SXW-1:0] sum_x, sum_y;
  logic signed [SQW-1:0] sum_xx, sum_yy;
  logic signed [SPW-1:0] sum_xy;

  logic [NW-1:0] n_eff, l_eff;
  logic          take, in_win, last;
  logic [8:0]    k9, l9, n9;
  int            tmp;

  logic signed [SW-1:0]  x;
  logic signed [31:0]    pxx, pyy, pxy;
  logic signed [SXW-1:0] nsx, nsy;
  logic signed [SQW-1:0] nsxx, nsyy;
  logic signed [SPW-1:0] nsxy;

  always_comb begin
    if (window_len == '0) begin
      n_eff = NW'(1);
    end else if (int'(window_len) > MAX_WINDOW) begin
      n_eff = NW'(MAX_WINDOW);
    end else begin
      n_eff = window_len;
    end
    if (int'(lag) > MAX_LAG - 1) begin
      l_eff = NW'(MAX_LAG - 1);
    end else begin
      l_eff = lag;
    end
    k9     = {1'b0, cnt};
    l9     = 9'(l_eff);
    n9     = 9'(n_eff);
    in_win = (k9 >= l9) && ((k9 - l9) < n9);
    last   = (k9 + 9'd1) >= (n9 + l9);
    tmp    = int'(wptr) - int'(l_eff);
    if (tmp < 0) begin
      tmp = tmp + MAX_LAG;
    end
    rd_addr = AW'(tmp);
    // keep room in the queue for window ends still in the accumulate and output stages
    full = ((3'(fifo_cnt) + 3'(s2_valid && s2_last) + 3'(win_push)) >= 3'd2);
    take = push && !full;
  end

  // delay memory
  always_ff @(posedge clk) begin
    if (take) begin
      mem[wptr] <= sample;
      rd_data   <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      cnt      <= '0;
      wptr     <= '0;
      s2_valid <= 1'b0;
      rd_vld   <= 1'b0;
    end else begin
      s2_valid <= take;
      if (take) begin
        vld[wptr] <= 1'b1;
        rd_vld    <= vld[rd_addr];
        if (last) begin
          cnt  <= '0;
          wptr <= '0;
        end else begin
          cnt <= cnt + 8'd1;
          if (int'(wptr) == MAX_LAG - 1) begin
            wptr <= '0;
          end else begin
            wptr <= wptr + AW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s2_s    <= sample;
      s2_acc  <= in_win;
      s2_byp  <= (l_eff == '0);
      s2_last <= last;
      s2_n    <= n_eff;
    end
  end

  always_comb begin
    if (s2_byp) begin
      x = s2_s;
    end else if (rd_vld) begin
      x = rd_data;
    end else begin
      x = '0;
    end
    pxx  = x * x;
    pyy  = s2_s * s2_s;
    pxy  = x * s2_s;
    nsx  = sum_x;
    nsy  = sum_y;
    nsxx = sum_xx;
    nsyy = sum_yy;
    nsxy = sum_xy;
    if (s2_acc) begin
      nsx  = sum_x + {{(SXW-SW){x[SW-1]}}, x};
      nsy  = sum_y + {{(SXW-SW){s2_s[SW-1]}}, s2_s};
      nsxx = sum_xx + {{(SQW-32){pxx[31]}}, pxx};
      nsyy = sum_yy + {{(SQW-32){pyy[31]}}, pyy};
      nsxy = sum_xy + {{(SPW-32){pxy[31]}}, pxy};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x    <= '0;
      sum_y    <= '0;
      sum_xx   <= '0;
      sum_yy   <= '0;
      sum_xy   <= '0;
      win_push <= 1'b0;
    end else begin
      win_push <= s2_valid && s2_last;
      if (s2_valid) begin
        if (s2_last) begin
          sum_x  <= '0;
          sum_y  <= '0;
          sum_xx <= '0;
          sum_yy <= '0;
          sum_xy <= '0;
        end else begin
          sum_x  <= nsx;
          sum_y  <= nsy;
          sum_xx <= nsxx;
          sum_yy <= nsyy;
          sum_xy <= nsxy;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_last) begin
      win.n   <= s2_n;
      win.sx  <= nsx;
      win.sy  <= nsy;
      win.sxx <= nsxx;
      win.syy <= nsyy;
      win.sxy <= nsxy;
    end
  end

endmodule
`default_nettype wire

>>> sv/lpc_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpc_fifo
// Two-entry queue of finished window records between front and back end.
// ----------------------------------------------------------------------------
module lpc_fifo (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      wr,
  input  lpc_pkg::win_t  wdata,
  input  wire logic      rd,
  output lpc_pkg::win_t  rdata,
  output logic [1:0]     cnt
);
  import lpc_pkg::*;

  win_t mem [2];
  logic wptr, rptr;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= '0;
    end else begin
      if (wr) begin
        wptr <= !wptr;
      end
      if (rd) begin
        rptr <= !rptr;
      end
      cnt <= 2'(cnt + 2'(wr) - 2'(rd));
    end
  end

  assign rdata = mem[rptr];

endmodule
`default_nettype wire

>>> sv/lpc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpc_back
// Turns window sums into the Q1.14 coefficient: variance terms, two
// sequential wide products and a bit-serial square root compare.
// ----------------------------------------------------------------------------
module lpc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              have,
  input  lpc_pkg::win_t          win,
  output logic                   take_win,
  input  wire logic              pop,
  output logic                   out_valid,
  output logic signed [15:0]     correlation,
  output logic                   degenerate
);
  import lpc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PROD = 3'd1;
  localparam logic [2:0] ST_DIFF = 3'd2;
  localparam logic [2:0] ST_MULD = 3'd3;
  localparam logic [2:0] ST_MULR = 3'd4;
  localparam logic [2:0] ST_SRCH = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0] state;
  win_t       w;

  logic signed [VW-1:0] p_nxx, p_nyy, p_nxy, p_xx, p_yy, p_xy;
  logic signed [VW-1:0] vx, vy, cv;
  logic [OW-1:0]        ux, uy, uc;
  logic                 neg, degen;

  logic [1:0]    mcnt;
  logic [MW-1:0] acc, acc_next, dval;
  logic [OW-1:0] op_a, op_b;
  logic [15:0]   chunk;
  logic [63:0]   mul;

  logic [BW-1:0] rval, pv, av, bv, tv;
  logic          le;
  logic [QW-1:0] q, qc;
  logic [3:0]    j;

  function automatic logic degen_next(input logic signed [VW-1:0] a,
                                      input logic signed [VW-1:0] b);
    degen_next = (a <= 0) || (b <= 0);
  endfunction

  always_comb begin
    vx = p_nxx - p_xx;
    vy = p_nyy - p_yy;
    cv = p_nxy - p_xy;
    if (state == ST_MULD) begin
      op_a = ux;
      op_b = uy;
    end else begin
      op_a = uc;
      op_b = uc;
    end
    case (mcnt)
      2'd0:    chunk = op_b[15:0];
      2'd1:    chunk = op_b[31:16];
      2'd2:    chunk = op_b[47:32];
      default: chunk = '0;
    endcase
    mul      = op_a * chunk;
    acc_next = {acc[MW-17:0], 16'b0} + MW'(mul);
    tv       = pv + av + bv;
    le       = tv <= rval;
    qc       = (q > ONE_Q14) ? ONE_Q14 : q;
    take_win = (state == ST_IDLE) && have;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && (!out_valid || pop)) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (have) begin
            state <= ST_PROD;
          end
        end
        ST_PROD: state <= ST_DIFF;
        ST_DIFF: state <= degen_next(vx, vy) ? ST_DONE : ST_MULD;
        ST_MULD: begin
          if (mcnt == 2'd0) begin
            state <= ST_MULR;
          end
        end
        ST_MULR: begin
          if (mcnt == 2'd0) begin
            state <= ST_SRCH;
          end
        end
        ST_SRCH: begin
          if (j == 4'd0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || pop) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (have) begin
          w <= win;
        end
      end
      ST_PROD: begin
        p_nxx <= $signed({1'b0, w.n}) * w.sxx;
        p_nyy <= $signed({1'b0, w.n}) * w.syy;
        p_nxy <= $signed({1'b0, w.n}) * w.sxy;
        p_xx  <= w.sx * w.sx;
        p_yy  <= w.sy * w.sy;
        p_xy  <= w.sx * w.sy;
      end
      ST_DIFF: begin
        degen <= degen_next(vx, vy);
        neg   <= cv < 0;
        ux    <= vx[OW-1:0];
        uy    <= vy[OW-1:0];
        uc    <= (cv < 0) ? 48'(-cv) : cv[OW-1:0];
        q     <= '0;
        acc   <= '0;
        mcnt  <= 2'd2;
      end
      ST_MULD: begin
        if (mcnt == 2'd0) begin
          dval <= acc_next;
          acc  <= '0;
          mcnt <= 2'd2;
        end else begin
          acc  <= acc_next;
          mcnt <= mcnt - 2'd1;
        end
      end
      ST_MULR: begin
        if (mcnt == 2'd0) begin
          rval <= BW'({acc_next, 28'b0});
          bv   <= BW'({dval, 28'b0});
          pv   <= '0;
          av   <= '0;
          j    <= 4'd14;
        end else begin
          acc  <= acc_next;
          mcnt <= mcnt - 2'd1;
        end
      end
      ST_SRCH: begin
        // test q with bit j set: q'^2*D = P + (q*D << (j+1)) + (D << 2j)
        if (le) begin
          pv <= tv;
          q  <= q | (QW'(1) << j);
          av <= (av + (bv << 1)) >> 1;
        end else begin
          av <= av >> 1;
        end
        bv <= bv >> 2;
        j  <= j - 4'd1;
      end
      ST_DONE: begin
        if (!out_valid || pop) begin
          degenerate <= degen;
          if (degen) begin
            correlation <= '0;
          end else if (neg) begin
            correlation <= -$signed({1'b0, qc});
          end else begin
            correlation <= $signed({1'b0, qc});
          end
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/lagged_pearson_correlation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lagged_pearson_correlation
// Lagged Pearson correlation of a Q5.10 sample stream, result in Q1.14.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while full is low; each is paired with
// the sample lag places later and window_len pairs are summed exactly.
// After window_len + lag samples the window closes and its sums go into a
// two-entry queue; the back end takes the next window only from idle, after
// two 48x16 three-step products and a 15-step square root compare. With
// short windows full rises until the back end drains the queue. Reset
// clears the delay line valid bits at once, so no clearing pass is needed.
// Registers: index 0 lag (reset 1), index 1 window_len (reset 50).
module lagged_pearson_correlation #(
  parameter int MAX_LAG    = 128,
  parameter int MAX_WINDOW = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [15:0] sample,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [15:0]      correlation,
  output logic                    degenerate,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [6:0]         cfg_data
);
  import lpc_pkg::*;

  logic [NW-1:0] lag, window_len;
  logic          win_push, take_win, out_valid;
  win_t          win_f, win_q;
  logic [1:0]    fifo_cnt;

  assign cfg_ready = 1'b1;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      lag        <= 7'd1;
      window_len <= 7'd50;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LAG: lag        <= cfg_data;
        REG_WIN: window_len <= cfg_data;
        default: ;
      endcase
    end
  end

  lpc_front #(
    .MAX_LAG    (MAX_LAG),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .sample     (sample),
    .lag        (lag),
    .window_len (window_len),
    .fifo_cnt   (fifo_cnt),
    .win_push   (win_push),
    .win        (win_f)
  );

  lpc_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (win_push),
    .wdata (win_f),
    .rd    (take_win),
    .rdata (win_q),
    .cnt   (fifo_cnt)
  );

  lpc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .have        (fifo_cnt != 2'd0),
    .win         (win_q),
    .take_win    (take_win),
    .pop         (pop),
    .out_valid   (out_valid),
    .correlation (correlation),
    .degenerate  (degenerate)
  );

`ifndef SYNTHESIS
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_cnt != 2'd3)
    else $error("window queue overflow");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    (fifo_cnt == 2'd2) |-> !win_push)
    else $error("window pushed into full queue");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && degenerate) |-> (correlation == 16'sd0))
    else $error("degenerate result not zero");

  a_corr_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (correlation <= 16'sd16384 && correlation >= -16'sd16384))
    else $error("correlation out of range");
`endif

endmodule
`default_nettype wire

>>> test/lagged_pearson_correlation_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagged_pearson_correlation_test
// Streams samples through the lagged correlator under several lag and window
// settings and checks every correlation result against an in-bench predictor
// built on exact integer sums and a bisection square root compare.
// ----------------------------------------------------------------------------
module lagged_pearson_correlation_test;
  import lpc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic signed [15:0] sample = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [15:0] correlation;
  logic degenerate;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_LAG;
  logic [6:0] cfg_data = '0;

  lagged_pearson_correlation dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .sample(sample),
    .empty(empty), .pop(pop), .correlation(correlation),
    .degenerate(degenerate), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic signed [15:0] corr;
    logic               degen;
  } corr_result_t;

  // predictor state
  logic [6:0] lag_reg = 7'd1;
  logic [6:0] win_reg = 7'd50;
  logic signed [15:0] hist [128];
  int unsigned count_k = 0;
  longint acc_x = 0, acc_y = 0, acc_xx = 0, acc_yy = 0, acc_xy = 0;

  corr_result_t expected_q [$];
  int errors = 0;
  bit push_idle_en = 1'b1;
  bit pop_idle_en = 1'b1;
  int pop_holdoff = 0;

  initial forever #5 clk = ~clk;

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // largest q in [0,16384] with q*q*vx*vy <= 2^28*c*c
  function automatic logic [14:0] root_ratio(logic [63:0] c, logic [63:0] vx,
                                             logic [63:0] vy);
    logic [191:0] rhs, den, t;
    int unsigned lo, hi, mid;
    rhs = ({128'd0, c} * {128'd0, c}) << 28;
    den = {128'd0, vx} * {128'd0, vy};
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = den * mid * mid;
      if (t <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo[14:0];
  endfunction

  task automatic predict_sample(logic signed [15:0] s);
    int unsigned n, l;
    longint x, vx, vy, cv, mag;
    corr_result_t r;
    n = win_reg;
    l = lag_reg;
    if (n < 1) n = 1;
    if (n > 64) n = 64;
    if (l > 127) l = 127;
    if (count_k >= l && count_k - l < n) begin
      x = (l == 0) ? longint'(s) : longint'(hist[(count_k - l) % 128]);
      acc_x += x;
      acc_y += s;
      acc_xx += x * x;
      acc_yy += longint'(s) * s;
      acc_xy += x * s;
    end
    hist[count_k % 128] = s;
    count_k++;
    if (count_k < n + l) return;
    vx = n * acc_xx - acc_x * acc_x;
    vy = n * acc_yy - acc_y * acc_y;
    cv = n * acc_xy - acc_x * acc_y;
    r.corr = '0;
    r.degen = 1'b0;
    if (vx <= 0 || vy <= 0) r.degen = 1'b1;
    else begin
      mag = cv < 0 ? -cv : cv;
      r.corr = {1'b0, root_ratio(mag, vx, vy)};
      if (cv < 0) r.corr = -r.corr;
    end
    expected_q.push_back(r);
    count_k = 0;
    acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xy = 0;
  endtask

  // push stays high on return so items can follow back to back
  task automatic send_sample(logic signed [15:0] s);
    if (push_idle_en && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    push <= 1'b1;
    sample <= s;
    do @(posedge clk); while (full);
    predict_sample(s);
    @(negedge clk);
  endtask

  task automatic drain;
    push <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_LAG) lag_reg = val;
    else win_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [6:0] l, logic [6:0] w);
    drain();
    write_reg(REG_LAG, l);
    write_reg(REG_WIN, w);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return $signed(16'($urandom_range(0, 64)) - 16'sd32);
      default: return $signed(16'($urandom));
    endcase
  endfunction

  task automatic test_directed;
    int i;
    configure(7'd1, 7'd3);
    for (i = 0; i < 4; i++) send_sample(16'sd100);       // zero variance
    for (i = 0; i < 4; i++) send_sample(i[0] ? 16'sh7fff : 16'sh8000);
    for (i = 0; i < 4; i++) send_sample(16'(i * 1000));   // positive trend
    configure(7'd0, 7'd2);                                // pair with itself
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    configure(7'd127, 7'd0);                              // window 0 acts as 1
    for (i = 0; i < 128; i++) send_sample(rand_sample());
    configure(7'd1, 7'd127);                              // clamp to 64
    for (i = 0; i < 65; i++) send_sample(rand_sample());
  endtask

  task automatic test_random;
    int i, p;
    for (p = 0; p < 8; p++) begin
      case (p)
        0: configure(7'd1, 7'd50);
        1: configure(7'd0, 7'd1);
        2: configure(7'd2, 7'd64);
        3: configure(7'd127, 7'd1);
        default: configure(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
      endcase
      for (i = 0; i < 200; i++) send_sample(rand_sample());
    end
  endtask

  task automatic test_backpressure;
    int i;
    configure(7'd0, 7'd1);
    pop_holdoff = 300;
    for (i = 0; i < 60; i++) send_sample(rand_sample());
    drain();
    configure(7'd3, 7'd5);
    for (i = 0; i < 40; i++) send_sample(rand_sample());
  endtask

  task automatic test_no_idle;
    int i;
    push_idle_en = 1'b0;
    pop_idle_en = 1'b0;
    configure(7'd1, 7'd4);
    for (i = 0; i < 300; i++) send_sample(rand_sample());
  endtask

  initial begin
    for (int i = 0; i < 128; i++) hist[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    test_backpressure();
    test_no_idle();
    drain();
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // result checker and receiver idling
  initial begin
    corr_result_t e;
    forever begin
      @(negedge clk);
      if (pop_holdoff > 0) begin
        pop <= 1'b0;
        pop_holdoff--;
      end else if (pop_idle_en && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk);
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          $error("unexpected item: correlation %0d degenerate %0d",
                 correlation, degenerate);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (correlation !== e.corr) begin
            $error("correlation expected %0d actual %0d", e.corr, correlation);
            errors++;
          end
          if (degenerate !== e.degen) begin
            $error("degenerate expected %0d actual %0d", e.degen, degenerate);
            errors++;
          end
        end
      end
    end
  end

endmodule

>>> lagged_pearson_correlation.f
sv/lpc_pkg.sv
sv/lpc_front.sv
sv/lpc_fifo.sv
sv/lpc_back.sv
sv/lagged_pearson_correlation.sv
test/lagged_pearson_correlation_test.sv
